/* rtl/core/psc_pkg.sv */
// Package for the prime sieve counter: field widths, controller states and
// the command/status structs between controller and datapath. No dependencies.
package psc_pkg;

   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned JUMP_W  = LIMIT_W + 1;
   localparam int unsigned SQ_W    = LIMIT_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_CHECK,
      ST_CROSS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic fill_wr;
      logic rd_first;
      logic advance;
      logic cross_load;
      logic cross_wr;
      logic count_inc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic limit_small;
      logic fill_last;
      logic mark;
      logic sq_in_range;
      logic i_last;
      logic j_in_range;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/psc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psc_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/psc_datapath.sv */
// Sieve datapath: limit, candidate, square, crossing pointer, count, the mark
// store and the result register. Depends on psc_pkg and psc_ram.
module psc_datapath
   import psc_pkg::*;
#(
   parameter int unsigned SIEVE_DEPTH = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [LIMIT_W-1:0] req_upper_limit,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [COUNT_W-1:0] rsp_prime_count
);

   localparam int unsigned AW = $clog2(SIEVE_DEPTH);
   localparam int unsigned MAX_LIMIT =
      (SIEVE_DEPTH - 1 > 65535) ? 65535 : SIEVE_DEPTH - 1;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] fill_ff, fill_in;
   logic [LIMIT_W-1:0] i_ff, i_in;
   logic [LIMIT_W-1:0] step_ff, step_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [JUMP_W-1:0]  j_ff, j_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_prime_count_ff, rsp_prime_count_in;

   logic               sq_in_range;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [0:0]         wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [0:0]         rd_data;
   logic [LIMIT_W-1:0] i_next;

   assign i_next      = i_ff + 1'b1;
   assign sq_in_range = sq_ff <= SQ_W'(limit_ff);

   always_comb begin
      limit_in           = limit_ff;
      fill_in            = fill_ff;
      i_in               = i_ff;
      step_in            = step_ff;
      sq_in              = sq_ff;
      j_in               = j_ff;
      count_in           = count_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_prime_count_in = rsp_prime_count_ff;

      if (cmd.start) begin
         limit_in = (req_upper_limit > LIMIT_W'(MAX_LIMIT)) ?
                    LIMIT_W'(MAX_LIMIT) : req_upper_limit;
         fill_in  = LIMIT_W'(2);
         i_in     = LIMIT_W'(2);
         sq_in    = SQ_W'(4);
         count_in = '0;
      end
      if (cmd.fill_wr) begin
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.cross_load) begin
         j_in    = JUMP_W'(sq_ff);
         step_in = i_ff;
      end
      if (cmd.advance) begin
         i_in = i_next;
         // square is frozen once past the limit
         if (sq_in_range) begin
            sq_in = sq_ff + SQ_W'({i_ff, 1'b1});
         end
      end
      if (cmd.cross_wr) begin
         j_in = j_ff + JUMP_W'(step_ff);
      end
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_prime_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff           <= limit_in;
      fill_ff            <= fill_in;
      i_ff               <= i_in;
      step_ff            <= step_in;
      sq_ff              <= sq_in;
      j_ff               <= j_in;
      count_ff           <= count_in;
      rsp_prime_count_ff <= rsp_prime_count_in;
   end

   always_comb begin
      wr_en   = cmd.fill_wr | cmd.cross_wr;
      wr_addr = cmd.fill_wr ? AW'(fill_ff) : AW'(j_ff);
      wr_data = cmd.fill_wr ? 1'b1 : 1'b0;
      rd_en   = cmd.rd_first | cmd.advance;
      rd_addr = cmd.rd_first ? AW'(i_ff) : AW'(i_next);
   end

   psc_ram #(
      .WIDTH (1),
      .DEPTH (SIEVE_DEPTH)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.limit_small = limit_ff < LIMIT_W'(2);
      status.fill_last   = fill_ff == limit_ff;
      status.mark        = rd_data[0];
      status.sq_in_range = sq_in_range;
      status.i_last      = i_ff == limit_ff;
      status.j_in_range  = j_ff <= JUMP_W'(limit_ff);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_prime_count_ff;

endmodule

/* rtl/core/psc_controller.sv */
// Sieve sequencer: fill, scan and crossing-off phases, result hand-off.
// Depends on psc_pkg.
module psc_controller
   import psc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_FILL;
            end
         end
         ST_FILL: begin
            if (status.limit_small) begin
               state_in = ST_DONE;
            end else begin
               cmd.fill_wr = 1'b1;
               if (status.fill_last) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_first = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.count_inc = status.mark;
            if (status.mark && status.sq_in_range) begin
               // next candidate is prefetched; crossings start past it
               cmd.cross_load = 1'b1;
               cmd.advance    = 1'b1;
               state_in       = ST_CROSS;
            end else if (status.i_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_CROSS: begin
            if (status.j_in_range) begin
               cmd.cross_wr = 1'b1;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/prime_sieve_counter.sv */
// Prime sieve counter top level: controller, datapath and mark store.
// Depends on psc_pkg, psc_controller, psc_datapath, psc_ram.
//
//   channel | ports                                | direction
//   --------+--------------------------------------+----------
//   request | req_valid, req_stall, req_upper_limit | in
//   result  | rsp_valid, rsp_stall, rsp_prime_count | out
//
// One item at a time. The run time grows with the saturated limit and is set by
// the single write port of the mark store (fill, then clears) and one read per
// candidate. A limit below two skips the fill and goes straight to the result.
// Synchronous reset clears the sequencer and the result valid; the mark store
// is rewritten by every item before use. The result sits in an output
// register, so a stalled result does not block the next request; a second
// finished result waits with the input stalled.
module prime_sieve_counter
   import psc_pkg::*;
#(
   parameter int unsigned SIEVE_DEPTH = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [LIMIT_W-1:0] req_upper_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COUNT_W-1:0] rsp_prime_count
);

   cmd_type    cmd;
   status_type status;

   psc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   psc_datapath #(
      .SIEVE_DEPTH (SIEVE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_upper_limit (req_upper_limit),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_prime_count (rsp_prime_count)
   );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for prime_sieve_counter: checks each prime count
// against a sieve computed in the testbench. Depends on psc_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import psc_pkg::*;

   localparam int unsigned SIEVE_DEPTH = 65536;
   localparam int unsigned QUIET_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 50;
   localparam int unsigned PHASE_ITEMS = 19;
   localparam int unsigned HOLDOFF_CYCLES = 400;

   class prime_count_board;
      int unsigned depth;
      bit marks[];
      logic [COUNT_W-1:0] expected_counts[$];
      int unsigned mismatches;
      int unsigned checked;

      function new(int unsigned depth_i);
         depth = depth_i;
         marks = new[depth_i];
         mismatches = 0;
         checked = 0;
      endfunction

      function logic [COUNT_W-1:0] count_primes(logic [LIMIT_W-1:0] upper);
         int unsigned lim;
         int unsigned total;
         longint unsigned j;
         lim = 32'(upper);
         total = 0;
         if (lim > depth - 1) begin
            lim = depth - 1;
         end
         if (lim >= 2) begin
            foreach (marks[k]) marks[k] = 1'b1;
            for (int unsigned i = 2; i <= lim; i++) begin
               if (marks[i]) begin
                  total++;
                  for (j = longint'(i) * i; j <= lim; j += i) marks[j] = 1'b0;
               end
            end
         end
         return total[COUNT_W-1:0];
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] ERROR: %s", $realtime, what);
         end
      endfunction

      function void note_limit(logic [LIMIT_W-1:0] upper);
         expected_counts = {expected_counts, count_primes(upper)};
      endfunction

      function void check_count(logic [COUNT_W-1:0] actual);
         logic [COUNT_W-1:0] want;
         if (expected_counts.size() == 0) begin
            flag($sformatf("unexpected count %0d", actual));
            return;
         end
         want = expected_counts.pop_front();
         checked++;
         if (actual !== want) begin
            flag($sformatf("prime_count expected %0d actual %0d", want, actual));
         end
      endfunction

      function int unsigned pending();
         return expected_counts.size();
      endfunction

      function void close();
         while (expected_counts.size() != 0) begin
            flag($sformatf("missing count %0d", expected_counts.pop_front()));
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [LIMIT_W-1:0] req_upper_limit = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [COUNT_W-1:0] rsp_prime_count;

   prime_count_board sb = new(SIEVE_DEPTH);

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned holdoff_left = 0;
   bit          holdoff_done = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned items_sent = 0;
   int unsigned max_limit = 0;

   logic [LIMIT_W-1:0] directed_limits[$] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd11, 16'd25, 16'd29,
      16'd49, 16'd100, 16'd121, 16'd255, 16'd256, 16'd1000, 16'd4096, 16'd65535,
      16'd2, 16'd30, 16'd32768, 16'd1, 16'd7919, 16'd13, 16'd0
   };

   prime_sieve_counter #(
      .SIEVE_DEPTH(SIEVE_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_upper_limit (req_upper_limit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_count (rsp_prime_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // long hold-off right after the first short item is accepted, so the block fills up
   always @(posedge clock) begin
      if (!holdoff_done && items_sent == 1) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
         rsp_stall <= 1'b1;
         holdoff_left = holdoff_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_limit(req_upper_limit);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_count(rsp_prime_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_limit(input logic [LIMIT_W-1:0] lim);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_upper_limit <= lim;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (lim > max_limit) begin
         max_limit = 32'(lim);
      end
   endtask

   // mostly small limits; the sieve time grows with the limit
   function automatic logic [LIMIT_W-1:0] random_limit();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return LIMIT_W'($urandom_range(3));
      if (pick < 80) return LIMIT_W'($urandom_range(255));
      if (pick < 96) return LIMIT_W'($urandom_range(2047));
      return LIMIT_W'($urandom_range(12000));
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_limits[k]) send_limit(directed_limits[k]);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 75;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 75;
            end
            default: begin
               send_idle_pct = 33;
               stall_pct = 33;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_limit(random_limit());
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close();

      $display("Sent %0d limits (largest %0d) under four idle/stall mixes and one long hold-off",
               items_sent, max_limit);
      $display("Checked %0d prime counts, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/psc_pkg.sv
rtl/core/psc_ram.sv
rtl/core/psc_datapath.sv
rtl/core/psc_controller.sv
rtl/core/prime_sieve_counter.sv
tb/sv/tb_top.sv
